### design/mid_pkg.sv
package mid_pkg;

  localparam int unsigned MAX_LENGTH = 15;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned FLAG_W     = 14;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] PFX_ESC0     = 4'd0;
  localparam logic [3:0] PFX_ESC1     = 4'd1;
  localparam logic [3:0] PFX_LOCK     = 4'd2;
  localparam logic [3:0] PFX_REPNE    = 4'd3;
  localparam logic [3:0] PFX_REP      = 4'd4;
  localparam logic [3:0] PFX_CS       = 4'd5;
  localparam logic [3:0] PFX_SS       = 4'd6;
  localparam logic [3:0] PFX_DS       = 4'd7;
  localparam logic [3:0] PFX_ES       = 4'd8;
  localparam logic [3:0] PFX_FS       = 4'd9;
  localparam logic [3:0] PFX_GS       = 4'd10;
  localparam logic [3:0] PFX_OPSIZE   = 4'd11;
  localparam logic [3:0] PFX_ADDRSIZE = 4'd12;

  localparam logic [7:0] OP_MOV_RM8_R8  = 8'h88;
  localparam logic [7:0] OP_MOV_RM_R    = 8'h89;
  localparam logic [7:0] OP_MOV_R8_RM8  = 8'h8a;
  localparam logic [7:0] OP_MOV_R_RM    = 8'h8b;
  localparam logic [7:0] OP_MOV_RM8_I8  = 8'hc6;
  localparam logic [7:0] OP_MOV_RM_I    = 8'hc7;
  localparam logic [7:0] OP_MOVZX_B     = 8'hb6;
  localparam logic [7:0] OP_MOVZX_W     = 8'hb7;

  localparam logic [1:0] WIDTH_BYTE  = 2'd0;
  localparam logic [1:0] WIDTH_WORD  = 2'd1;
  localparam logic [1:0] WIDTH_DWORD = 2'd2;
  localparam logic [1:0] WIDTH_QWORD = 2'd3;

  localparam logic [1:0] DIR_MEM_TO_REG = 2'd0;
  localparam logic [1:0] DIR_REG_TO_MEM = 2'd1;
  localparam logic [1:0] DIR_IMM_TO_MEM = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [7:0] instr_byte;
    logic       start_of_instruction;
  } mid_in_t;

  typedef struct packed {
    logic [13:0] prefix_flags;
    logic [7:0]  rex_byte;
    logic [7:0]  opcode_byte;
    logic [7:0]  modrm_byte;
    logic [3:0]  reg_number;
    logic [3:0]  rm_number;
    logic [1:0]  access_width;
    logic [1:0]  operand_direction;
    logic [31:0] immediate_value;
    logic [3:0]  total_length;
    logic        decode_status;
  } mid_out_t;

  typedef struct packed {
    logic [7:0] instr_byte;
    logic       start;
    logic       prefix_hit;
    logic [3:0] prefix_idx;
    logic       is_rex;
    logic       op_ok;
  } mid_word_t;

endpackage

### design/x86_mov_instruction_decoder_top.sv
// Decodes MOV and MOVZX instructions presented one byte per word, with the first byte of each
// instruction marked. A front stage classifies every byte and places it in a four-word queue,
// and a back stage walks the prefix, REX, opcode, ModRM and immediate phases at one byte per
// cycle, so that while the output side does not hold off the block sustains one input word per
// clock. A result word is loaded into the output register at the clock edge at which the queue
// hands over the byte that completes or fails the instruction. Input is stalled only while the
// queue is full, which happens only when the output side holds off.
module x86_mov_instruction_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mid_pkg::mid_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mid_pkg::mid_out_t out_data
);
  import mid_pkg::*;

  logic      q_valid;
  logic      q_pop;
  mid_word_t q_word;

  mid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  mid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### design/mid_front.sv
module mid_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mid_pkg::mid_in_t   in_data,
  output logic               q_valid,
  output mid_pkg::mid_word_t q_word,
  input  logic               q_pop
);
  import mid_pkg::*;

  mid_word_t         cls;
  mid_word_t         queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  always_comb begin
    cls            = '0;
    cls.instr_byte = in_data.instr_byte;
    cls.start      = in_data.start_of_instruction;
    cls.prefix_hit = 1'b1;
    unique case (in_data.instr_byte) inside
      8'h0f:         cls.prefix_idx = PFX_ESC0;
      8'h38, 8'h3a:  cls.prefix_idx = PFX_ESC1;
      8'hf0:         cls.prefix_idx = PFX_LOCK;
      8'hf2:         cls.prefix_idx = PFX_REPNE;
      8'hf3:         cls.prefix_idx = PFX_REP;
      8'h2e:         cls.prefix_idx = PFX_CS;
      8'h36:         cls.prefix_idx = PFX_SS;
      8'h3e:         cls.prefix_idx = PFX_DS;
      8'h26:         cls.prefix_idx = PFX_ES;
      8'h64:         cls.prefix_idx = PFX_FS;
      8'h65:         cls.prefix_idx = PFX_GS;
      8'h66:         cls.prefix_idx = PFX_OPSIZE;
      8'h67:         cls.prefix_idx = PFX_ADDRSIZE;
      default: begin
        cls.prefix_hit = 1'b0;
        cls.prefix_idx = PFX_ESC0;
      end
    endcase
    cls.is_rex = (in_data.instr_byte[7:4] == 4'h4);
    cls.op_ok  = (in_data.instr_byte == OP_MOV_RM8_R8) ||
                 (in_data.instr_byte == OP_MOV_RM_R)   ||
                 (in_data.instr_byte == OP_MOV_R8_RM8) ||
                 (in_data.instr_byte == OP_MOV_R_RM)   ||
                 (in_data.instr_byte == OP_MOV_RM8_I8) ||
                 (in_data.instr_byte == OP_MOV_RM_I)   ||
                 (in_data.instr_byte == OP_MOVZX_B)    ||
                 (in_data.instr_byte == OP_MOVZX_W);
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### design/mid_back.sv
module mid_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mid_pkg::mid_word_t q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mid_pkg::mid_out_t  out_data
);
  import mid_pkg::*;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_OPCODE,
    PH_MODRM,
    PH_IMM,
    PH_IDLE
  } phase_t;

  phase_t             phase_r, phase_nxt, phase_b;
  logic [FLAG_W-1:0]  flags_r, flags_nxt, flags_b;
  logic [7:0]         rex_r, rex_nxt, rex_b;
  logic [7:0]         opcode_r, opcode_nxt, opcode_b;
  logic [7:0]         modrm_r, modrm_nxt, modrm_b;
  logic [31:0]        imm_r, imm_nxt, imm_b;
  logic [2:0]         left_r, left_nxt, left_b;
  logic [LEN_W-1:0]   len_r, len_nxt, len_b;
  logic               out_valid_r;
  mid_out_t           out_data_r;
  mid_out_t           result;
  logic               emit;
  logic               err;
  logic [2:0]         imm_size;
  logic [1:0]         pos;
  logic [1:0]         width_code;
  logic [1:0]         dir_code;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (q_word.start) begin
      phase_b  = PH_PREFIX;
      flags_b  = '0;
      rex_b    = '0;
      opcode_b = '0;
      modrm_b  = '0;
      imm_b    = '0;
      left_b   = '0;
      len_b    = '0;
    end else begin
      phase_b  = phase_r;
      flags_b  = flags_r;
      rex_b    = rex_r;
      opcode_b = opcode_r;
      modrm_b  = modrm_r;
      imm_b    = imm_r;
      left_b   = left_r;
      len_b    = len_r;
    end

    if (opcode_b == OP_MOV_RM8_I8) begin
      imm_size = 3'd1;
    end else if (opcode_b == OP_MOV_RM_I) begin
      imm_size = flags_b[PFX_OPSIZE] ? 3'd2 : 3'd4;
    end else begin
      imm_size = 3'd0;
    end
    pos = 2'(imm_size - left_b);

    phase_nxt  = phase_b;
    flags_nxt  = flags_b;
    rex_nxt    = rex_b;
    opcode_nxt = opcode_b;
    modrm_nxt  = modrm_b;
    imm_nxt    = imm_b;
    left_nxt   = left_b;
    len_nxt    = len_b;
    emit       = 1'b0;
    err        = 1'b0;

    if (phase_b != PH_IDLE) begin
      if (len_b >= LEN_W'(MAX_LENGTH)) begin
        emit = 1'b1;
        err  = 1'b1;
      end else begin
        unique case (phase_b) inside
          PH_PREFIX, PH_OPCODE: begin
            if (phase_b == PH_PREFIX && q_word.prefix_hit) begin
              flags_nxt[q_word.prefix_idx] = 1'b1;
              len_nxt = len_b + 1'b1;
            end else if (phase_b == PH_PREFIX && q_word.is_rex) begin
              rex_nxt   = q_word.instr_byte;
              len_nxt   = len_b + 1'b1;
              phase_nxt = PH_OPCODE;
            end else if (!q_word.op_ok) begin
              emit = 1'b1;
              err  = 1'b1;
            end else begin
              opcode_nxt = q_word.instr_byte;
              len_nxt    = len_b + 1'b1;
              phase_nxt  = PH_MODRM;
            end
          end
          PH_MODRM: begin
            modrm_nxt = q_word.instr_byte;
            len_nxt   = len_b + 1'b1;
            left_nxt  = imm_size;
            if (imm_size == 3'd0) begin
              emit = 1'b1;
            end else begin
              phase_nxt = PH_IMM;
            end
          end
          PH_IMM: begin
            imm_nxt  = imm_b | (32'(q_word.instr_byte) << {pos, 3'b000});
            left_nxt = left_b - 1'b1;
            len_nxt  = len_b + 1'b1;
            if (left_b == 3'd1) begin
              emit = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    unique case (opcode_nxt) inside
      OP_MOV_RM8_R8, OP_MOV_R8_RM8, OP_MOV_RM8_I8, OP_MOVZX_B: width_code = WIDTH_BYTE;
      OP_MOVZX_W: width_code = WIDTH_WORD;
      default: begin
        if (flags_nxt[PFX_OPSIZE]) begin
          width_code = WIDTH_WORD;
        end else if (rex_nxt[3]) begin
          width_code = WIDTH_QWORD;
        end else begin
          width_code = WIDTH_DWORD;
        end
      end
    endcase

    if (opcode_nxt == OP_MOV_RM8_R8 || opcode_nxt == OP_MOV_RM_R) begin
      dir_code = DIR_REG_TO_MEM;
    end else if (opcode_nxt == OP_MOV_RM8_I8 || opcode_nxt == OP_MOV_RM_I) begin
      dir_code = DIR_IMM_TO_MEM;
    end else begin
      dir_code = DIR_MEM_TO_REG;
    end

    result.prefix_flags      = flags_nxt;
    result.rex_byte          = rex_nxt;
    result.opcode_byte       = opcode_nxt;
    result.modrm_byte        = modrm_nxt;
    result.reg_number        = {rex_nxt[2], modrm_nxt[5:3]};
    result.rm_number         = {rex_nxt[0], modrm_nxt[2:0]};
    result.access_width      = err ? WIDTH_BYTE : width_code;
    result.operand_direction = err ? DIR_MEM_TO_REG : dir_code;
    result.immediate_value   = err ? 32'd0 : imm_nxt;
    result.total_length      = len_nxt;
    result.decode_status     = err ? STATUS_ERROR : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PREFIX;
      flags_r     <= '0;
      rex_r       <= '0;
      opcode_r    <= '0;
      modrm_r     <= '0;
      imm_r       <= '0;
      left_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r  <= phase_nxt;
        flags_r  <= flags_nxt;
        rex_r    <= rex_nxt;
        opcode_r <= opcode_nxt;
        modrm_r  <= modrm_nxt;
        imm_r    <= imm_nxt;
        left_r   <= left_nxt;
        len_r    <= len_nxt;
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mid_pkg::*;

  localparam logic [7:0] PB_ESC0     = 8'h0f;
  localparam logic [7:0] PB_ESC38    = 8'h38;
  localparam logic [7:0] PB_ESC3A    = 8'h3a;
  localparam logic [7:0] PB_LOCK     = 8'hf0;
  localparam logic [7:0] PB_REPNE    = 8'hf2;
  localparam logic [7:0] PB_REP      = 8'hf3;
  localparam logic [7:0] PB_CS       = 8'h2e;
  localparam logic [7:0] PB_SS       = 8'h36;
  localparam logic [7:0] PB_DS       = 8'h3e;
  localparam logic [7:0] PB_ES       = 8'h26;
  localparam logic [7:0] PB_FS       = 8'h64;
  localparam logic [7:0] PB_GS       = 8'h65;
  localparam logic [7:0] PB_OPSIZE   = 8'h66;
  localparam logic [7:0] PB_ADDRSIZE = 8'h67;
  localparam logic [7:0] REX_BASE    = 8'h40;
  localparam logic [7:0] BAD_OPCODE  = 8'h90;

  localparam int unsigned STREAM_WORDS   = 1950;
  localparam int unsigned QUIET_FROM     = 400;
  localparam int unsigned QUIET_TO       = 900;
  localparam int unsigned HOLD_START     = 1500;
  localparam int unsigned HOLD_LEN       = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned REPORT_LIMIT   = 50;

  typedef enum logic [2:0] {PH_PREFIX, PH_OPCODE, PH_MODRM, PH_IMM, PH_IDLE} decode_phase_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  mid_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mid_out_t out_data;

  mid_in_t  byte_stream_q [$];
  mid_out_t decoded_q [$];
  int unsigned words_total = 0;
  int unsigned words_accepted = 0;
  int unsigned mov_words = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_run = 0;
  int unsigned holdoff_left = 0;

  decode_phase_t phase_q = PH_PREFIX;
  logic [13:0]   flags_q = '0;
  logic [7:0]    rex_q = '0;
  logic [7:0]    opc_q = '0;
  logic [7:0]    modrm_q = '0;
  logic [31:0]   imm_q = '0;
  logic [2:0]    imm_left_q = '0;
  logic [3:0]    len_q = '0;

  wire idle_allowed = cycle_count < QUIET_FROM || cycle_count >= QUIET_TO;

  x86_mov_instruction_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] prefix_byte(int idx);
    case (idx)
      0:       return PB_ESC0;
      1:       return PB_ESC38;
      2:       return PB_ESC3A;
      3:       return PB_LOCK;
      4:       return PB_REPNE;
      5:       return PB_REP;
      6:       return PB_CS;
      7:       return PB_SS;
      8:       return PB_DS;
      9:       return PB_ES;
      10:      return PB_FS;
      11:      return PB_GS;
      12:      return PB_OPSIZE;
      default: return PB_ADDRSIZE;
    endcase
  endfunction

  function automatic logic [7:0] mov_opcode(int idx);
    case (idx)
      0:       return OP_MOV_RM8_R8;
      1:       return OP_MOV_RM_R;
      2:       return OP_MOV_R8_RM8;
      3:       return OP_MOV_R_RM;
      4:       return OP_MOV_RM8_I8;
      5:       return OP_MOV_RM_I;
      6:       return OP_MOVZX_B;
      default: return OP_MOVZX_W;
    endcase
  endfunction

  function automatic int prefix_slot(logic [7:0] b);
    case (b) inside
      PB_ESC0:           return PFX_ESC0;
      PB_ESC38, PB_ESC3A: return PFX_ESC1;
      PB_LOCK:           return PFX_LOCK;
      PB_REPNE:          return PFX_REPNE;
      PB_REP:            return PFX_REP;
      PB_CS:             return PFX_CS;
      PB_SS:             return PFX_SS;
      PB_DS:             return PFX_DS;
      PB_ES:             return PFX_ES;
      PB_FS:             return PFX_FS;
      PB_GS:             return PFX_GS;
      PB_OPSIZE:         return PFX_OPSIZE;
      PB_ADDRSIZE:       return PFX_ADDRSIZE;
      default:           return -1;
    endcase
  endfunction

  function automatic logic is_mov_opcode(logic [7:0] b);
    return b == OP_MOV_RM8_R8 || b == OP_MOV_RM_R || b == OP_MOV_R8_RM8 || b == OP_MOV_R_RM ||
           b == OP_MOV_RM8_I8 || b == OP_MOV_RM_I || b == OP_MOVZX_B || b == OP_MOVZX_W;
  endfunction

  function automatic logic [2:0] imm_bytes_for(logic [7:0] opc, logic [13:0] flags);
    if (opc == OP_MOV_RM8_I8) return 3'd1;
    if (opc == OP_MOV_RM_I) return flags[PFX_OPSIZE] ? 3'd2 : 3'd4;
    return 3'd0;
  endfunction

  function automatic logic [1:0] access_width_for(logic [7:0] opc, logic [13:0] flags,
                                                  logic [7:0] rex);
    case (opc) inside
      OP_MOV_RM8_R8, OP_MOV_R8_RM8, OP_MOV_RM8_I8, OP_MOVZX_B: return WIDTH_BYTE;
      OP_MOVZX_W: return WIDTH_WORD;
      default: begin
        if (flags[PFX_OPSIZE]) return WIDTH_WORD;
        if (rex[3]) return WIDTH_QWORD;
        return WIDTH_DWORD;
      end
    endcase
  endfunction

  function automatic logic [1:0] direction_for(logic [7:0] opc);
    if (opc == OP_MOV_RM8_R8 || opc == OP_MOV_RM_R) return DIR_REG_TO_MEM;
    if (opc == OP_MOV_RM8_I8 || opc == OP_MOV_RM_I) return DIR_IMM_TO_MEM;
    return DIR_MEM_TO_REG;
  endfunction

  function automatic void clear_decode();
    phase_q    = PH_PREFIX;
    flags_q    = '0;
    rex_q      = '0;
    opc_q      = '0;
    modrm_q    = '0;
    imm_q      = '0;
    imm_left_q = '0;
    len_q      = '0;
  endfunction

  function automatic void finish_decode(logic failed);
    mid_out_t r;
    r.prefix_flags      = flags_q;
    r.rex_byte          = rex_q;
    r.opcode_byte       = opc_q;
    r.modrm_byte        = modrm_q;
    r.reg_number        = {rex_q[2], modrm_q[5:3]};
    r.rm_number         = {rex_q[0], modrm_q[2:0]};
    r.access_width      = failed ? '0 : access_width_for(opc_q, flags_q, rex_q);
    r.operand_direction = failed ? '0 : direction_for(opc_q);
    r.immediate_value   = failed ? '0 : imm_q;
    r.total_length      = len_q;
    r.decode_status     = failed ? STATUS_ERROR : STATUS_OK;
    decoded_q.push_back(r);
    phase_q = PH_IDLE;
  endfunction

  function automatic void decode_byte(mid_in_t w);
    logic [7:0] b;
    logic [1:0] pos;
    int slot;
    b = w.instr_byte;
    if (w.start_of_instruction) clear_decode();
    if (phase_q == PH_IDLE) return;
    if (len_q >= MAX_LENGTH) begin
      finish_decode(1'b1);
      return;
    end
    case (phase_q) inside
      PH_PREFIX, PH_OPCODE: begin
        slot = (phase_q == PH_PREFIX) ? prefix_slot(b) : -1;
        if (slot >= 0) begin
          flags_q[slot] = 1'b1;
          len_q = len_q + 1'b1;
        end else if (phase_q == PH_PREFIX && b[7:4] == REX_BASE[7:4]) begin
          rex_q   = b;
          len_q   = len_q + 1'b1;
          phase_q = PH_OPCODE;
        end else if (!is_mov_opcode(b)) begin
          finish_decode(1'b1);
        end else begin
          opc_q   = b;
          len_q   = len_q + 1'b1;
          phase_q = PH_MODRM;
        end
      end
      PH_MODRM: begin
        modrm_q    = b;
        len_q      = len_q + 1'b1;
        imm_left_q = imm_bytes_for(opc_q, flags_q);
        if (imm_left_q == 0) finish_decode(1'b0);
        else phase_q = PH_IMM;
      end
      PH_IMM: begin
        pos        = 2'(imm_bytes_for(opc_q, flags_q) - imm_left_q);
        imm_q      = imm_q | (32'(b) << {pos, 3'b000});
        imm_left_q = imm_left_q - 1'b1;
        len_q      = len_q + 1'b1;
        if (imm_left_q == 0) finish_decode(1'b0);
      end
      default: phase_q = PH_IDLE;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT) $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void put_word(logic [7:0] b, logic s);
    mid_in_t w;
    w.instr_byte           = b;
    w.start_of_instruction = s;
    byte_stream_q.push_back(w);
  endfunction

  // Builds one MOV instruction with random content; some are cut short and
  // some carry a long run of prefixes that overruns the length limit.
  function automatic void put_instruction();
    logic [7:0] seq [$];
    logic [7:0] opc;
    logic       opsize;
    int         npfx, nimm, keep;
    opsize = 1'b0;
    if ($urandom_range(99) < 5) npfx = $urandom_range(16, 12);
    else npfx = $urandom_range(3);
    for (int i = 0; i < npfx; i++) seq.push_back(prefix_byte($urandom_range(13)));
    if ($urandom_range(99) < 30) seq.push_back(PB_OPSIZE);
    foreach (seq[i]) if (seq[i] == PB_OPSIZE) opsize = 1'b1;
    if ($urandom_range(1)) seq.push_back(REX_BASE | 8'($urandom_range(15)));
    opc = mov_opcode($urandom_range(7));
    seq.push_back(opc);
    seq.push_back(8'($urandom_range(255)));
    if (opc == OP_MOV_RM8_I8) nimm = 1;
    else if (opc == OP_MOV_RM_I) nimm = opsize ? 2 : 4;
    else nimm = 0;
    for (int i = 0; i < nimm; i++) seq.push_back(8'($urandom_range(255)));
    keep = seq.size();
    if ($urandom_range(99) < 10) keep = $urandom_range(seq.size() - 1, 1);
    for (int i = 0; i < keep; i++) put_word(seq[i], i == 0);
    mov_words += keep;
    if ($urandom_range(99) < 10) begin
      for (int i = $urandom_range(3, 1); i > 0; i--) begin
        put_word(8'($urandom_range(255)), 1'b0);
        mov_words++;
      end
    end
  endfunction

  function automatic void put_noise();
    int n;
    n = $urandom_range(5, 1);
    for (int i = 0; i < n; i++) put_word(8'($urandom_range(255)), i == 0 || $urandom_range(99) < 20);
    mov_words += n;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_stream_q.size() != 0 && !(idle_allowed && $urandom_range(99) < 10)) begin
          in_data  <= byte_stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mid_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT) $error("decoded word arrived with none expected");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("prefix_flags", 32'(want.prefix_flags), 32'(out_data.prefix_flags));
          check_field("rex_byte", 32'(want.rex_byte), 32'(out_data.rex_byte));
          check_field("opcode_byte", 32'(want.opcode_byte), 32'(out_data.opcode_byte));
          check_field("modrm_byte", 32'(want.modrm_byte), 32'(out_data.modrm_byte));
          check_field("reg_number", 32'(want.reg_number), 32'(out_data.reg_number));
          check_field("rm_number", 32'(want.rm_number), 32'(out_data.rm_number));
          check_field("access_width", 32'(want.access_width), 32'(out_data.access_width));
          check_field("operand_direction", 32'(want.operand_direction),
                      32'(out_data.operand_direction));
          check_field("immediate_value", want.immediate_value, out_data.immediate_value);
          check_field("total_length", 32'(want.total_length), 32'(out_data.total_length));
          check_field("decode_status", 32'(want.decode_status),
                      32'(out_data.decode_status));
        end
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (cycle_count == HOLD_START) begin
        holdoff_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_allowed && $urandom_range(99) < 10;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_run <= 0;
    end else if (quiet_run == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_run <= quiet_run + 1;
    end
  end

  initial begin
    // Without a start mark after reset the first bytes still form an instruction.
    put_word(OP_MOV_RM8_R8, 1'b0);
    put_word(8'hc0, 1'b0);
    put_word(8'h55, 1'b0);
    put_word(PB_OPSIZE, 1'b1);
    put_word(OP_MOV_RM_I, 1'b0);
    put_word(8'h05, 1'b0);
    put_word(8'h34, 1'b0);
    put_word(8'h12, 1'b0);
    put_word(REX_BASE | 8'h0f, 1'b1);
    put_word(OP_MOV_RM_I, 1'b0);
    put_word(8'hff, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(8'hff, 1'b0);
    put_word(8'h80, 1'b0);
    put_word(8'h7f, 1'b0);
    put_word(PB_ESC0, 1'b1);
    put_word(OP_MOVZX_W, 1'b0);
    put_word(8'h38, 1'b0);
    put_word(BAD_OPCODE, 1'b1);
    put_word(REX_BASE | 8'h01, 1'b1);
    put_word(PB_OPSIZE, 1'b0);
    put_word(OP_MOV_RM8_I8, 1'b1);
    put_word(8'h00, 1'b0);
    put_word(8'hff, 1'b0);
    mov_words = byte_stream_q.size();
    while (mov_words < STREAM_WORDS) begin
      if ($urandom_range(99) < 85) put_instruction();
      else put_noise();
    end
    words_total = byte_stream_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (words_accepted != words_total || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
